// ----- design/pgm_image_byte_formatter_assert.svh -----
// Assertion macros shared by the PGM byte formatter RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef PGM_IMAGE_BYTE_FORMATTER_ASSERT_SVH
`define PGM_IMAGE_BYTE_FORMATTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define PGMFMT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pgmfmt: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define PGMFMT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pgmfmt: next-cycle check failed");

`endif

// ----- design/pgmfmt_pkg.sv -----
// Package for the PGM byte formatter: queue entry type, back-end phases,
// character codes and configuration register indexes. No dependencies.
package pgmfmt_pkg;

  localparam int DIM_BITS_DEFAULT    = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int CFG_DATA_BITS       = 16;
  localparam int CFG_INDEX_BITS      = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_ASCII_MODE   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd2;

  // Character codes.
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_P     = 8'h50;

  localparam logic signed [7:0] BUDGET_START   = 8'sd70;
  localparam logic signed [7:0] BUDGET_RESTART = 8'sd69;

  // Header number conversion: 16-bit values, divide by ten by reciprocal.
  localparam int          CONV_BITS   = 16;
  localparam int          NUM_DIGITS  = 5;
  localparam int          RECIP_BITS  = 17;
  localparam logic [16:0] RECIP_10    = 17'd52429;
  localparam int          RECIP_SHIFT = 19;

  // One classified pixel request handed from the front end to the back end.
  typedef struct packed {
    logic       err;        // zero dimension: single error byte
    logic       hdr;        // first pixel of an image: header goes first
    logic       ascii;      // P2 text output for this pixel
    logic       nl_before;  // line budget ran out: newline before the digits
    logic       row_end;    // last pixel of its row
    logic [1:0] ndig;       // decimal digit count, 1 to 3
    logic [7:0] pixel;
    logic [1:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } pgmfmt_entry_t;

  typedef enum logic [4:0] {
    PH_FIRST,
    PH_ERR,
    PH_P,
    PH_MODE,
    PH_NL_A,
    PH_WCONV,
    PH_WDIG,
    PH_SP_A,
    PH_HCONV,
    PH_HDIG,
    PH_SP_B,
    PH_TWO,
    PH_FIVE_A,
    PH_FIVE_B,
    PH_NL_B,
    PH_NL_PRE,
    PH_HUND,
    PH_TENS,
    PH_ONES,
    PH_SPACE,
    PH_NL_ROW,
    PH_RAW
  } pgmfmt_phase_t;

endpackage

// ----- design/pgmfmt_front.sv -----
// Front end of the PGM byte formatter: accepts pixel requests, tracks the
// raster position and line budget, and classifies each pixel. Uses pgmfmt_pkg.
module pgmfmt_front #(
  parameter int DIM_BITS = pgmfmt_pkg::DIM_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_pixel,
  input  logic                          ascii_mode,
  input  logic [DIM_BITS-1:0]           image_width,
  input  logic [DIM_BITS-1:0]           image_height,
  input  logic                          q_full,
  output logic                          q_push,
  output pgmfmt_pkg::pgmfmt_entry_t     q_entry
);
  import pgmfmt_pkg::*;

  logic [DIM_BITS-1:0] column_r, column_nxt;
  logic [DIM_BITS-1:0] row_r, row_nxt;
  logic signed [7:0]   budget_r, budget_nxt;

  logic [DIM_BITS:0]   col_inc;
  logic [DIM_BITS-1:0] row_inc;
  logic                err;
  logic                row_end;
  logic                nl_before;
  logic [1:0]          ndig;
  logic [9:0]          bcd;
  logic signed [7:0]   budget_base;
  logic signed [7:0]   cost;

  // Shift-and-add-3 conversion of one pixel value to three BCD digits.
  function automatic logic [9:0] bin_to_bcd(input logic [7:0] v);
    logic [17:0] sr;
    sr = {10'd0, v};
    for (int i = 0; i < 8; i++) begin
      if (sr[11:8] >= 4'd5) sr[11:8] = sr[11:8] + 4'd3;
      if (sr[15:12] >= 4'd5) sr[15:12] = sr[15:12] + 4'd3;
      sr = sr << 1;
    end
    return sr[17:8];
  endfunction

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    bcd       = bin_to_bcd(in_pixel);
    ndig      = (in_pixel >= 8'd100) ? 2'd3 : ((in_pixel >= 8'd10) ? 2'd2 : 2'd1);
    err       = (image_width == '0) || (image_height == '0);
    col_inc   = {1'b0, column_r} + {{DIM_BITS{1'b0}}, 1'b1};
    row_end   = (col_inc >= {1'b0, image_width});
    row_inc   = row_r + {{(DIM_BITS-1){1'b0}}, 1'b1};
    nl_before = ascii_mode && (budget_r < 8'sd0);

    q_entry.err       = err;
    q_entry.hdr       = (column_r == '0) && (row_r == '0);
    q_entry.ascii     = ascii_mode;
    q_entry.nl_before = nl_before;
    q_entry.row_end   = row_end;
    q_entry.ndig      = ndig;
    q_entry.pixel     = in_pixel;
    q_entry.hund      = bcd[9:8];
    q_entry.tens      = bcd[7:4];
    q_entry.ones      = bcd[3:0];

    budget_base = nl_before ? BUDGET_RESTART : budget_r;
    cost        = $signed({6'd0, ndig} + 8'd1);

    if (row_end) begin
      column_nxt = '0;
      budget_nxt = BUDGET_START;
      row_nxt    = ((row_inc >= image_height) || (row_inc == '0)) ? '0 : row_inc;
    end else begin
      column_nxt = col_inc[DIM_BITS-1:0];
      budget_nxt = ascii_mode ? (budget_base - cost) : budget_r;
      row_nxt    = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      row_r    <= '0;
      budget_r <= BUDGET_START;
    end else if (q_push && !err) begin
      column_r <= column_nxt;
      row_r    <= row_nxt;
      budget_r <= budget_nxt;
    end
  end

endmodule

// ----- design/pgmfmt_queue.sv -----
// Small first-word-fall-through queue of classified pixel requests between
// the front and back ends of the PGM byte formatter. Uses pgmfmt_pkg.
module pgmfmt_queue #(
  parameter int DEPTH = pgmfmt_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  pgmfmt_pkg::pgmfmt_entry_t push_data,
  output logic                      full,
  input  logic                      pop,
  output pgmfmt_pkg::pgmfmt_entry_t head,
  output logic                      head_valid
);
  import pgmfmt_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pgmfmt_entry_t    entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_nxt;
      if (pop)  rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r] <= push_data;
  end

endmodule

// ----- design/pgmfmt_back.sv -----
// Back end of the PGM byte formatter: expands each queued pixel request into
// header, digit and separator bytes behind one output register. Uses pgmfmt_pkg.
`include "pgm_image_byte_formatter_assert.svh"

module pgmfmt_back #(
  parameter int DIM_BITS = pgmfmt_pkg::DIM_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pgmfmt_pkg::pgmfmt_entry_t head,
  input  logic                      head_valid,
  output logic                      pop,
  input  logic [DIM_BITS-1:0]       image_width,
  input  logic [DIM_BITS-1:0]       image_height,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_byte,
  output logic                      out_last,
  output logic                      out_error
);
  import pgmfmt_pkg::*;

  pgmfmt_phase_t  state_r, state_nxt;
  pgmfmt_phase_t  phase;

  logic [2:0]           cnt_r;
  logic [2:0]           idx_r;
  logic [CONV_BITS-1:0] conv_val_r;
  logic [3:0]           dig_r [NUM_DIGITS];

  logic                 out_valid_r;
  logic [7:0]           out_byte_r;
  logic                 out_last_r;
  logic                 out_error_r;

  logic                 adv;
  logic                 step;
  logic                 emit;
  logic                 last_val;
  logic                 err_val;
  logic [7:0]           byte_val;
  logic                 conv_en;

  logic [CONV_BITS-1:0]            conv_src;
  logic [CONV_BITS-1:0]            conv_in;
  logic [CONV_BITS+RECIP_BITS-1:0] conv_prod;
  logic [CONV_BITS-1:0]            conv_quo;
  logic [CONV_BITS-1:0]            conv_q10;
  logic [3:0]                      conv_rem;
  logic [2:0]                      conv_msd;

  function automatic pgmfmt_phase_t digit_start(input pgmfmt_entry_t e);
    unique case (e.ndig)
      2'd3:    return PH_HUND;
      2'd2:    return PH_TENS;
      default: return PH_ONES;
    endcase
  endfunction

  function automatic pgmfmt_phase_t pixel_start(input pgmfmt_entry_t e);
    if (!e.ascii)    return PH_RAW;
    if (e.nl_before) return PH_NL_PRE;
    return digit_start(e);
  endfunction

  function automatic pgmfmt_phase_t first_phase(input pgmfmt_entry_t e);
    if (e.err) return PH_ERR;
    if (e.hdr) return PH_P;
    return pixel_start(e);
  endfunction

  assign adv   = !out_valid_r || !out_stall;
  assign step  = head_valid && adv;
  assign phase = (state_r == PH_FIRST) ? first_phase(head) : state_r;
  assign pop   = step && emit && last_val;

  // Header number conversion: one decimal digit per cycle unless the output stalls, least significant first.
  always_comb begin
    conv_src  = (phase == PH_WCONV) ? CONV_BITS'(image_width) : CONV_BITS'(image_height);
    conv_in   = (cnt_r == 3'd0) ? conv_src : conv_val_r;
    conv_prod = {{(CONV_BITS+RECIP_BITS-RECIP_BITS){1'b0}}, RECIP_10} *
                {{RECIP_BITS{1'b0}}, conv_in};
    conv_quo  = CONV_BITS'(conv_prod[CONV_BITS+RECIP_BITS-1:RECIP_SHIFT]);
    conv_q10  = (conv_quo << 3) + (conv_quo << 1);
    conv_rem  = 4'(conv_in - conv_q10);
    if (conv_src >= CONV_BITS'(10000))     conv_msd = 3'd4;
    else if (conv_src >= CONV_BITS'(1000)) conv_msd = 3'd3;
    else if (conv_src >= CONV_BITS'(100))  conv_msd = 3'd2;
    else if (conv_src >= CONV_BITS'(10))   conv_msd = 3'd1;
    else                                   conv_msd = 3'd0;
  end

  // Output decode of the current phase.
  always_comb begin
    emit     = 1'b1;
    last_val = 1'b0;
    err_val  = 1'b0;
    byte_val = CH_SPACE;
    conv_en  = 1'b0;
    unique case (phase)
      PH_ERR: begin
        byte_val = 8'd0;
        last_val = 1'b1;
        err_val  = 1'b1;
      end
      PH_P:                       byte_val = CH_P;
      PH_MODE:                    byte_val = head.ascii ? CH_TWO : CH_FIVE;
      PH_NL_A, PH_NL_B, PH_NL_PRE: byte_val = CH_NL;
      PH_WCONV, PH_HCONV: begin
        emit    = 1'b0;
        conv_en = 1'b1;
      end
      PH_WDIG, PH_HDIG:           byte_val = CH_ZERO + {4'd0, dig_r[idx_r]};
      PH_SP_A, PH_SP_B:           byte_val = CH_SPACE;
      PH_TWO:                     byte_val = CH_TWO;
      PH_FIVE_A, PH_FIVE_B:       byte_val = CH_FIVE;
      PH_HUND:                    byte_val = CH_ZERO + {6'd0, head.hund};
      PH_TENS:                    byte_val = CH_ZERO + {4'd0, head.tens};
      PH_ONES:                    byte_val = CH_ZERO + {4'd0, head.ones};
      PH_SPACE: begin
        byte_val = CH_SPACE;
        last_val = !head.row_end;
      end
      PH_NL_ROW: begin
        byte_val = CH_NL;
        last_val = 1'b1;
      end
      PH_RAW: begin
        byte_val = head.pixel;
        last_val = 1'b1;
      end
      default:                    emit = 1'b0;
    endcase
  end

  // Next-phase sequencing.
  always_comb begin
    state_nxt = state_r;
    if (step) begin
      if (emit && last_val) begin
        state_nxt = PH_FIRST;
      end else begin
        unique case (phase)
          PH_P:      state_nxt = PH_MODE;
          PH_MODE:   state_nxt = PH_NL_A;
          PH_NL_A:   state_nxt = PH_WCONV;
          PH_WCONV:  state_nxt = (cnt_r == 3'd4) ? PH_WDIG : PH_WCONV;
          PH_WDIG:   state_nxt = (idx_r == 3'd0) ? PH_SP_A : PH_WDIG;
          PH_SP_A:   state_nxt = PH_HCONV;
          PH_HCONV:  state_nxt = (cnt_r == 3'd4) ? PH_HDIG : PH_HCONV;
          PH_HDIG:   state_nxt = (idx_r == 3'd0) ? PH_SP_B : PH_HDIG;
          PH_SP_B:   state_nxt = PH_TWO;
          PH_TWO:    state_nxt = PH_FIVE_A;
          PH_FIVE_A: state_nxt = PH_FIVE_B;
          PH_FIVE_B: state_nxt = PH_NL_B;
          PH_NL_B:   state_nxt = pixel_start(head);
          PH_NL_PRE: state_nxt = digit_start(head);
          PH_HUND:   state_nxt = PH_TENS;
          PH_TENS:   state_nxt = PH_ONES;
          PH_ONES:   state_nxt = PH_SPACE;
          PH_SPACE:  state_nxt = PH_NL_ROW;
          default:   state_nxt = PH_FIRST;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= PH_FIRST;
      cnt_r       <= 3'd0;
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (step && conv_en) begin
        cnt_r <= (cnt_r == 3'd4) ? 3'd0 : cnt_r + 3'd1;
        if (cnt_r == 3'd4) idx_r <= conv_msd;
      end
      if (step && (phase == PH_WDIG || phase == PH_HDIG) && idx_r != 3'd0) begin
        idx_r <= idx_r - 3'd1;
      end
      if (adv) out_valid_r <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && conv_en) begin
      dig_r[cnt_r] <= conv_rem;
      conv_val_r   <= conv_quo;
    end
    if (step && emit) begin
      out_byte_r  <= byte_val;
      out_last_r  <= last_val;
      out_error_r <= err_val;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;
  assign out_error = out_error_r;

  `PGMFMT_ASSERT_IMP(a_err_byte, out_valid_r && out_error_r, (out_byte_r == 8'd0) && out_last_r)
  `PGMFMT_ASSERT_IMP(a_busy_has_head, state_r != PH_FIRST, head_valid)
  `PGMFMT_ASSERT_IMP(a_digit_range, (phase == PH_WDIG) || (phase == PH_HDIG), dig_r[idx_r] <= 4'd9)
  `PGMFMT_ASSERT_NEXT(a_pop_restarts, pop, state_r == PH_FIRST)

endmodule

// ----- design/pgm_image_byte_formatter.sv -----
// Top level of the PGM byte formatter: configuration registers, front end,
// request queue and back end. Uses pgmfmt_pkg, pgmfmt_front/queue/back.
//
// Pixels enter in raster order and leave as the bytes of a PGM file, one byte
// per cycle from the output register while out_stall is low. A binary (P5)
// pixel gives one byte, an ASCII (P2) pixel two to six. The first pixel of an
// image also carries the header: up to 19 bytes, after converting the width and
// height (one decimal digit per cycle through a reciprocal multiplier, unless
// the output stalls). A small queue lets the front end keep accepting pixels
// while the back end works. A zero width or height answers each pixel with a
// single error result. Registers must be written by the user only while the
// block is idle; the block itself does not enforce it. cfg_ready is always high.
module pgm_image_byte_formatter #(
  parameter int DIM_BITS    = pgmfmt_pkg::DIM_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = pgmfmt_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_pixel,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [7:0]                           out_byte,
  output logic                                 out_last,
  output logic                                 out_error,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pgmfmt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [pgmfmt_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import pgmfmt_pkg::*;

  logic                ascii_mode_r;
  logic [DIM_BITS-1:0] width_r;
  logic [DIM_BITS-1:0] height_r;

  logic                q_full;
  logic                q_push;
  logic                q_pop;
  logic                q_head_valid;
  pgmfmt_entry_t       q_entry;
  pgmfmt_entry_t       q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ascii_mode_r <= 1'b0;
      width_r      <= '0;
      height_r     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ASCII_MODE:   ascii_mode_r <= cfg_data[0];
        REG_IMAGE_WIDTH:  width_r      <= cfg_data[DIM_BITS-1:0];
        REG_IMAGE_HEIGHT: height_r     <= cfg_data[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  pgmfmt_front #(
    .DIM_BITS (DIM_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pixel     (in_pixel),
    .ascii_mode   (ascii_mode_r),
    .image_width  (width_r),
    .image_height (height_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  pgmfmt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_head_valid)
  );

  pgmfmt_back #(
    .DIM_BITS (DIM_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (q_head),
    .head_valid   (q_head_valid),
    .pop          (q_pop),
    .image_width  (width_r),
    .image_height (height_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .out_error    (out_error)
  );

endmodule

// ----- tb/pgm_image_byte_formatter_checker.sv -----
// Checker for the PGM byte formatter: watches the pixel, byte and register
// channels, predicts the byte stream and compares it. Depends on pgmfmt_pkg.
`timescale 1ns / 1ps

module pgm_image_byte_formatter_checker
  import pgmfmt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [7:0]                in_pixel,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [7:0]                out_byte,
  input  logic                      out_last,
  input  logic                      out_error,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output int                        bytes_pending,
  output int                        mismatch_count
);

  localparam int unsigned MAX_GREY    = 255;
  localparam int          REPORT_CAP  = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } pgm_byte_t;

  pgm_byte_t   file_bytes[$];
  logic        ascii_mode;
  int unsigned image_width;
  int unsigned image_height;
  int unsigned column;
  int unsigned row;
  int          line_budget;
  int          mismatches;

  function automatic void push_char(logic [7:0] ch);
    file_bytes.push_back('{ch, 1'b0, 1'b0});
  endfunction

  function automatic void push_decimal(int unsigned value);
    logic [3:0] digs[5];
    int         cnt;
    cnt = 0;
    do begin
      digs[cnt] = 4'(value % 10);
      value     = value / 10;
      cnt++;
    end while (value != 0 && cnt < 5);
    for (int i = cnt - 1; i >= 0; i--) begin
      push_char(CH_ZERO + 8'(digs[i]));
    end
  endfunction

  // Appends every byte that one pixel request produces.
  function automatic void format_pixel(logic [7:0] pix);
    bit row_end;
    if (image_width == 0 || image_height == 0) begin
      file_bytes.push_back('{8'h00, 1'b1, 1'b1});
      return;
    end
    if (column == 0 && row == 0) begin
      push_char(CH_P);
      push_char(ascii_mode ? CH_TWO : CH_FIVE);
      push_char(CH_NL);
      push_decimal(image_width);
      push_char(CH_SPACE);
      push_decimal(image_height);
      push_char(CH_SPACE);
      push_decimal(MAX_GREY);
      push_char(CH_NL);
    end
    row_end = (column + 1 >= image_width);
    if (!ascii_mode) begin
      push_char(pix);
    end else begin
      if (line_budget < 0) begin
        line_budget = int'(BUDGET_RESTART);
        push_char(CH_NL);
      end
      if (pix >= 100) begin
        push_char(CH_ZERO + pix / 100);
        push_char(CH_ZERO + (pix / 10) % 10);
        push_char(CH_ZERO + pix % 10);
        line_budget -= 4;
      end else if (pix >= 10) begin
        push_char(CH_ZERO + pix / 10);
        push_char(CH_ZERO + pix % 10);
        line_budget -= 3;
      end else begin
        push_char(CH_ZERO + pix);
        line_budget -= 2;
      end
      push_char(CH_SPACE);
      if (row_end) push_char(CH_NL);
    end
    if (row_end) begin
      column      = 0;
      line_budget = int'(BUDGET_START);
      row         = (row + 1) & 32'hFFFF;
      // A shrunken height can leave the row past the end; the image wraps.
      if (row >= image_height || row == 0) row = 0;
    end else begin
      column = (column + 1) & 32'hFFFF;
    end
    file_bytes[file_bytes.size() - 1].last = 1'b1;
  endfunction

  function automatic void note_mismatch(string field, int exp_val, int act_val);
    if (mismatches < REPORT_CAP) begin
      $error("%s: expected %0h, actual %0h", field, exp_val, act_val);
    end
    mismatches++;
  endfunction

  always @(posedge clk) begin
    pgm_byte_t want;
    if (!rst_n) begin
      file_bytes.delete();
      ascii_mode   = 1'b0;
      image_width  = 0;
      image_height = 0;
      column       = 0;
      row          = 0;
      line_budget  = int'(BUDGET_START);
      mismatches   = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ASCII_MODE:   ascii_mode   = cfg_data[0];
          REG_IMAGE_WIDTH:  image_width  = cfg_data;
          REG_IMAGE_HEIGHT: image_height = cfg_data;
          default: ;
        endcase
      end
      // Results leave a register, so a byte taken here never belongs to a
      // request taken at the same edge.
      if (out_valid && !out_stall) begin
        if (file_bytes.size() == 0) begin
          if (mismatches < REPORT_CAP) begin
            $error("out_byte: no request waiting, actual %0h", out_byte);
          end
          mismatches++;
        end else begin
          want = file_bytes.pop_front();
          if (out_byte !== want.data) note_mismatch("out_byte", want.data, out_byte);
          if (out_last !== want.last) note_mismatch("last", want.last, out_last);
          if (out_error !== want.err) note_mismatch("error", want.err, out_error);
        end
      end
      if (in_valid && !in_stall) format_pixel(in_pixel);
    end
    bytes_pending  <= file_bytes.size();
    mismatch_count <= mismatches;
  end

endmodule

// ----- tb/pgm_image_byte_formatter_tb.sv -----
// Top of the PGM byte formatter testbench: clock, reset, pixel and register
// stimulus, random stalls and the verdict. Uses pgmfmt_pkg and the checker.
`timescale 1ns / 1ps

module pgm_image_byte_formatter_tb;
  import pgmfmt_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam int RANDOM_PIXELS = 260;
  localparam int IDLE_LIMIT    = 2000;
  localparam int TAIL_CYCLES   = 40;
  localparam int MAX_DIM       = 65535;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [7:0]                in_pixel;
  logic                      out_valid;
  logic                      out_stall;
  logic [7:0]                out_byte;
  logic                      out_last;
  logic                      out_error;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  int                        bytes_pending;
  int                        mismatch_count;
  bit                        in_calm;
  bit                        out_calm;

  pgm_image_byte_formatter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pixel  (in_pixel),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_error (out_error),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pgm_image_byte_formatter_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .out_error      (out_error),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .bytes_pending  (bytes_pending),
    .mismatch_count (mismatch_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Sender and receiver each switch now and then into a run without gaps.
  function automatic int draw_wait(ref bit calm);
    if ($urandom_range(0, 15) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 11))
      0:       return 8'd0;
      1:       return 8'd9;
      2:       return 8'd10;
      3:       return 8'd99;
      4:       return 8'd100;
      5:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int unsigned pick_width();
    case ($urandom_range(0, 11))
      0:       return 0;
      1:       return MAX_DIM;
      2:       return $urandom_range(0, MAX_DIM);
      3, 4:    return $urandom_range(15, 40);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  function automatic int unsigned pick_height();
    case ($urandom_range(0, 11))
      0:       return 0;
      1:       return MAX_DIM;
      2:       return $urandom_range(0, MAX_DIM);
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  task automatic send_pixel(logic [7:0] pix);
    int gap;
    gap = draw_wait(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= pix;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (bytes_pending != 0);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic cfg_write(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_format(logic mode, int unsigned width, int unsigned height);
    wait_drain();
    // Upper data bits of the mode write are noise the block must drop.
    cfg_write(REG_ASCII_MODE, {15'($urandom_range(0, 32767)), mode});
    cfg_write(REG_IMAGE_WIDTH, 16'(width));
    cfg_write(REG_IMAGE_HEIGHT, 16'(height));
    if ($urandom_range(0, 5) == 0) cfg_write(REG_UNUSED, 16'($urandom_range(0, MAX_DIM)));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      n = draw_wait(out_calm);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int sent;
    int burst;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_pixel  <= 8'h00;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ASCII_MODE;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers still at reset: zero dimensions give error bytes.
    send_pixel(8'h00);
    send_pixel(8'hFF);
    set_format(1'b0, 0, 2);
    send_pixel(8'h55);
    set_format(1'b0, 2, 0);
    send_pixel(8'hAA);
    // Largest header, then shrink the image under the current position.
    set_format(1'b0, MAX_DIM, MAX_DIM);
    send_pixel(8'h5A);
    set_format(1'b1, 1, 1);
    send_pixel(8'd7);
    set_format(1'b1, 2, 2);
    send_pixel(8'd0);
    send_pixel(8'd10);
    send_pixel(8'd100);
    send_pixel(8'd255);
    // Nineteen three-digit pixels overrun the line budget on one row.
    set_format(1'b1, 19, 1);
    repeat (19) send_pixel(8'd255);

    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      set_format(1'($urandom_range(0, 1)), pick_width(), pick_height());
      burst = $urandom_range(8, 40);
      for (int i = 0; i < burst; i++) begin
        // Now and then hold the next request until the stream has drained.
        if ($urandom_range(0, 24) == 0) wait_drain();
        send_pixel(pick_pixel());
        sent++;
      end
    end

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && bytes_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
